@@ rtl/csi_esc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csi_esc_pkg;

	localparam int VALUE_BITS = 16;
	localparam int PROD_BITS = VALUE_BITS + 4;
	localparam int CMP_BITS = (VALUE_BITS > 16) ? VALUE_BITS : 16;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_OPEN = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] BYTE_MAX = 8'hFF;
	localparam logic [7:0] SEQ_START_LEN = 8'd2;

	localparam logic [1:0] KIND_SEMI = 2'd0;
	localparam logic [1:0] KIND_FINAL = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
	localparam logic [15:0] OUT_VALUE_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_ESC   = 3'b010,
		PH_PARAM = 3'b100
	} phase_t;

	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		return (v == BYTE_MAX) ? v : v + 8'd1;
	endfunction

endpackage

`default_nettype wire

@@ rtl/csi_escape_parameter_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Parser for ESC '[' parameter sequences on a byte stream.
// The input channel (in_valid, in_stall, char_code) takes one character per
// transfer. The output channel (out_valid, out_stall and the result fields)
// gives one result for every field that a ';', a final letter or any other
// character ends; text outside a sequence gives no result.
// A character is captured in an input register at the transfer edge, and any
// result it gives is then written to the output register once that can take it.
// One character is taken per cycle while the receiver does not stall. The parser state is updated by the
// single stage between the two registers, which sets that rate.
// When the receiver stalls, the output register holds its result, the input
// register holds its character, and in_stall rises while both are full. A new
// character is still taken while a result waits, as long as the input
// register is free.
// Reset clears both valid flags and returns the parser to the idle phase with
// all counters at zero.
module csi_escape_parameter_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [15:0]      value,
	output logic [7:0]       field_index,
	output logic             has_digits,
	output logic [7:0]       final_char,
	output logic [7:0]       seq_length,
	output logic [7:0]       value_count
);
	import csi_esc_pkg::*;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  advance;
	logic                  fire;

	phase_t                phase_q, phase_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic                  digit_seen_q, digit_seen_d;
	logic [7:0]            field_cnt_q, field_cnt_d;
	logic [7:0]            digit_cnt_q, digit_cnt_d;
	logic [7:0]            byte_cnt_q, byte_cnt_d;

	logic                  res_valid;
	logic [1:0]            res_kind;
	logic [7:0]            res_final;
	logic                  res_last;
	logic [7:0]            res_len;

	logic                  is_digit;
	logic                  is_letter;
	logic [PROD_BITS-1:0]  acc_x;
	logic [PROD_BITS-1:0]  prod;
	logic [CMP_BITS-1:0]   acc_cmp;
	logic [15:0]           acc_clamped;
	logic [7:0]            cnt_total;

	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [15:0]           value_q;
	logic [7:0]            field_index_q;
	logic                  has_digits_q;
	logic [7:0]            final_char_q;
	logic [7:0]            seq_length_q;
	logic [7:0]            value_count_q;

	assign advance = !out_valid_q || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && (!valid_s1 || advance)) begin
			char_s1 <= char_code;
		end
	end

	assign is_digit = (char_s1 >= 8'h30) && (char_s1 <= 8'h39);
	assign is_letter = ((char_s1 >= 8'h41) && (char_s1 <= 8'h5A)) ||
		((char_s1 >= 8'h61) && (char_s1 <= 8'h7A));

	assign acc_x = PROD_BITS'(acc_q);
	assign prod = (acc_x << 3) + (acc_x << 1) + PROD_BITS'(char_s1[3:0]);

	assign acc_cmp = CMP_BITS'(acc_q);
	assign acc_clamped = (acc_cmp > CMP_BITS'(OUT_VALUE_MAX)) ? OUT_VALUE_MAX : acc_cmp[15:0];
	assign cnt_total = digit_seen_q ? sat_inc8(digit_cnt_q) : digit_cnt_q;

	always_comb begin
		phase_d = phase_q;
		acc_d = acc_q;
		digit_seen_d = digit_seen_q;
		field_cnt_d = field_cnt_q;
		digit_cnt_d = digit_cnt_q;
		byte_cnt_d = byte_cnt_q;
		res_valid = 1'b0;
		res_kind = KIND_SEMI;
		res_final = 8'd0;
		res_last = 1'b0;
		res_len = byte_cnt_q;
		unique case (phase_q)
			PH_ESC: begin
				if (char_s1 == CH_OPEN) begin
					phase_d = PH_PARAM;
					acc_d = '0;
					digit_seen_d = 1'b0;
					field_cnt_d = 8'd0;
					digit_cnt_d = 8'd0;
					byte_cnt_d = SEQ_START_LEN;
				end else if (char_s1 != CH_ESC) begin
					phase_d = PH_IDLE;
				end
			end
			PH_PARAM: begin
				if (is_digit) begin
					acc_d = (prod > PROD_BITS'(VALUE_MAX)) ? VALUE_MAX : prod[VALUE_BITS-1:0];
					digit_seen_d = 1'b1;
					byte_cnt_d = sat_inc8(byte_cnt_q);
				end else if (char_s1 == CH_SEMI) begin
					byte_cnt_d = sat_inc8(byte_cnt_q);
					res_valid = 1'b1;
					res_kind = KIND_SEMI;
					if (digit_seen_q) begin
						digit_cnt_d = sat_inc8(digit_cnt_q);
					end
					field_cnt_d = sat_inc8(field_cnt_q);
					acc_d = '0;
					digit_seen_d = 1'b0;
				end else if (is_letter) begin
					byte_cnt_d = sat_inc8(byte_cnt_q);
					res_valid = 1'b1;
					res_kind = KIND_FINAL;
					res_final = char_s1;
					res_last = 1'b1;
					res_len = sat_inc8(byte_cnt_q);
					phase_d = PH_IDLE;
				end else begin
					res_valid = 1'b1;
					res_kind = KIND_ABORT;
					res_last = 1'b1;
					phase_d = (char_s1 == CH_ESC) ? PH_ESC : PH_IDLE;
				end
			end
			default: begin
				phase_d = (char_s1 == CH_ESC) ? PH_ESC : PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q <= '0;
			digit_seen_q <= 1'b0;
			field_cnt_q <= 8'd0;
			digit_cnt_q <= 8'd0;
			byte_cnt_q <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			digit_seen_q <= digit_seen_d;
			field_cnt_q <= field_cnt_d;
			digit_cnt_q <= digit_cnt_d;
			byte_cnt_q <= byte_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind_q <= res_kind;
			value_q <= acc_clamped;
			field_index_q <= field_cnt_q;
			has_digits_q <= digit_seen_q;
			final_char_q <= res_final;
			seq_length_q <= res_last ? res_len : 8'd0;
			value_count_q <= res_last ? cnt_total : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign value = value_q;
	assign field_index = field_index_q;
	assign has_digits = has_digits_q;
	assign final_char = final_char_q;
	assign seq_length = seq_length_q;
	assign value_count = value_count_q;

	// A field closed by a semicolon never carries sequence totals.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_SEMI) |->
			(seq_length == 8'd0) && (value_count == 8'd0) && (final_char == 8'd0))
		else $error("semicolon result carries sequence totals");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_SEMI) || (kind == KIND_FINAL) || (kind == KIND_ABORT))
		else $error("result kind out of range");

	// ESC, '[' and the final letter are always counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_FINAL) |-> (seq_length >= 8'd3) && (final_char != 8'd0))
		else $error("final result with short length or missing letter");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_digits |-> (value == 16'd0))
		else $error("empty field with nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && valid_s1)
		else $error("input stalled while the output can move");

endmodule

`default_nettype wire

@@ bench/tb_csi_escape_parameter_parser.sv @@
`timescale 1ns / 1ps

module tb_csi_escape_parameter_parser;
	import csi_esc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic [7:0]  field_index;
		logic        has_digits;
		logic [7:0]  final_char;
		logic [7:0]  seq_length;
		logic [7:0]  value_count;
	} csi_field_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [15:0] value;
	logic [7:0]  field_index;
	logic        has_digits;
	logic [7:0]  final_char;
	logic [7:0]  seq_length;
	logic [7:0]  value_count;

	phase_t      seq_phase;
	logic [63:0] field_acc;
	logic        field_has_digit;
	logic [7:0]  field_num;
	logic [7:0]  digit_fields;
	logic [7:0]  seq_bytes;

	csi_field_t  pending_fields [$];
	csi_field_t  want;
	int          error_count = 0;
	int          chars_sent = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	int          burst_left = 0;
	bit          tx_idle_en;
	bit          rx_idle_en;

	csi_escape_parameter_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value(value),
		.field_index(field_index),
		.has_digits(has_digits),
		.final_char(final_char),
		.seq_length(seq_length),
		.value_count(value_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic void queue_field(input logic [1:0] k, input logic [7:0] fin,
			input bit last);
		csi_field_t r;
		logic [7:0] cnt;
		cnt = field_has_digit ? bump(digit_fields) : digit_fields;
		r.kind = k;
		r.value = (field_acc > 64'hFFFF) ? 16'hFFFF : field_acc[15:0];
		r.field_index = field_num;
		r.has_digits = field_has_digit;
		r.final_char = fin;
		r.seq_length = last ? seq_bytes : 8'd0;
		r.value_count = last ? cnt : 8'd0;
		pending_fields.push_back(r);
	endfunction

	function automatic void predict_char(input logic [7:0] c);
		logic [63:0] top;
		logic [63:0] digit;
		top = (64'd1 << VALUE_BITS) - 64'd1;
		digit = 64'(c) - 64'h30;
		case (seq_phase)
			PH_ESC: begin
				if (c == CH_OPEN) begin
					field_acc = '0;
					field_has_digit = 1'b0;
					field_num = 8'd0;
					digit_fields = 8'd0;
					seq_bytes = 8'd2;
					seq_phase = PH_PARAM;
				end else if (c != CH_ESC) begin
					seq_phase = PH_IDLE;
				end
			end
			PH_PARAM: begin
				if (c >= "0" && c <= "9") begin
					if (field_acc > (top - digit) / 10)
						field_acc = top;
					else
						field_acc = field_acc * 10 + digit;
					field_has_digit = 1'b1;
					seq_bytes = bump(seq_bytes);
				end else if (c == CH_SEMI) begin
					seq_bytes = bump(seq_bytes);
					queue_field(KIND_SEMI, 8'd0, 1'b0);
					if (field_has_digit)
						digit_fields = bump(digit_fields);
					field_num = bump(field_num);
					field_acc = '0;
					field_has_digit = 1'b0;
				end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
					seq_bytes = bump(seq_bytes);
					queue_field(KIND_FINAL, c, 1'b1);
					seq_phase = PH_IDLE;
				end else begin
					queue_field(KIND_ABORT, 8'd0, 1'b1);
					seq_phase = (c == CH_ESC) ? PH_ESC : PH_IDLE;
				end
			end
			default: begin
				seq_phase = (c == CH_ESC) ? PH_ESC : PH_IDLE;
			end
		endcase
	endfunction

	task automatic send_char(input logic [7:0] c);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_char(c);
		chars_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random_sequence();
		int nf;
		int nd;
		int pick;
		if ($urandom_range(0, 9) < 2) begin
			repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
			return;
		end
		send_char(CH_ESC);
		if ($urandom_range(0, 19) == 0) begin
			send_char(8'($urandom_range(0, 255)));
			return;
		end
		send_char(CH_OPEN);
		nf = $urandom_range(0, 4);
		for (int i = 0; i <= nf; i++) begin
			nd = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 3);
			repeat (nd) send_char(8'("0" + $urandom_range(0, 9)));
			if (i < nf)
				send_char(CH_SEMI);
		end
		pick = $urandom_range(0, 9);
		if (pick < 4)
			send_char(8'("A" + $urandom_range(0, 25)));
		else if (pick < 7)
			send_char(8'("a" + $urandom_range(0, 25)));
		else if (pick == 7)
			send_char(CH_ESC);
		else
			send_char(8'($urandom_range(0, 255)));
	endtask

	task automatic test_directed();
		logic [7:0] script [$] = '{
			"x", 8'h00, 8'hFF, CH_ESC, "q",
			CH_ESC, CH_ESC, CH_OPEN, "A",
			CH_ESC, CH_OPEN, "6", "5", "5", "3", "6", CH_SEMI, CH_SEMI, "9", "z",
			CH_ESC, CH_OPEN, "7", CH_ESC, CH_OPEN, "0", CH_SEMI, "@",
			CH_ESC, CH_OPEN, "Z", CH_ESC, CH_OPEN, "a", "{"
		};
		foreach (script[i]) send_char(script[i]);
	endtask

	task automatic test_long_sequence();
		send_char(CH_ESC);
		send_char(CH_OPEN);
		for (int i = 0; i < 260; i++) begin
			if (i % 4 == 0)
				send_char(8'("0" + $urandom_range(0, 9)));
			send_char(CH_SEMI);
		end
		send_char("9");
		send_char("m");
	endtask

	// The receiver holds off long enough for both pipeline registers to fill.
	task automatic test_backpressure();
		hold_left = 200;
		send_char(CH_ESC);
		send_char(CH_OPEN);
		repeat (30) begin
			send_char(8'("0" + $urandom_range(0, 9)));
			send_char(CH_SEMI);
		end
		send_char("H");
		drain();
	endtask

	task automatic test_random_streams();
		int start;
		start = chars_sent;
		while (chars_sent - start < 150) send_random_sequence();
	endtask

	task automatic test_steady_stream();
		int start;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		start = chars_sent;
		while (chars_sent - start < 60) send_random_sequence();
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, got_v);
			error_count++;
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
				out_stall <= 1'b1;
				burst_left = $urandom_range(0, 12);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fields.size() == 0) begin
				$display("%0t: result transfer with none expected, actual kind %0d value %0d",
					$time, kind, value);
				error_count++;
			end else begin
				want = pending_fields.pop_front();
				check_field("kind", 16'(want.kind), 16'(kind));
				check_field("value", want.value, value);
				check_field("field_index", 16'(want.field_index), 16'(field_index));
				check_field("has_digits", 16'(want.has_digits), 16'(has_digits));
				check_field("final_char", 16'(want.final_char), 16'(final_char));
				check_field("seq_length", 16'(want.seq_length), 16'(seq_length));
				check_field("value_count", 16'(want.value_count), 16'(value_count));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL csi_escape_parameter_parser");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = 8'd0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		seq_phase = PH_IDLE;
		field_acc = '0;
		field_has_digit = 1'b0;
		field_num = 8'd0;
		digit_fields = 8'd0;
		seq_bytes = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		test_long_sequence();
		drain();
		test_backpressure();
		test_random_streams();
		drain();
		test_steady_stream();
		drain();
		repeat (6) @(posedge clk);
		if (error_count == 0)
			$display("PASS csi_escape_parameter_parser");
		else
			$display("FAIL csi_escape_parameter_parser");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/csi_esc_pkg.sv
rtl/csi_escape_parameter_parser.sv
bench/tb_csi_escape_parameter_parser.sv
